/* sv/mode_s_preamble_detect_demod_macros.svh */
// Assertion macros for the Mode S preamble detector and demodulator.
`ifndef MODE_S_PREAMBLE_DETECT_DEMOD_MACROS_SVH
`define MODE_S_PREAMBLE_DETECT_DEMOD_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define MSPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masks the check.
`define MSPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mspd_pkg.sv */
// Shared constants, slicing tables, DF decode and types for the Mode S demodulator.
package mspd_pkg;

    localparam int C_WINDOW_DEPTH = 512;
    localparam int C_LONG_BITS    = 112;
    localparam int C_SHORT_BITS   = 56;
    localparam int C_LOOKAHEAD    = 290;
    localparam int C_DATA_START   = 19;
    localparam int C_PRE_LEN      = 19;
    localparam int C_NUM_TRY      = 5;
    localparam int C_QUEUE_DEPTH  = 4;
    // last sample index streamed: correlators look up to three samples ahead
    localparam int C_K_LAST       = C_LOOKAHEAD + 2;

    // correlator kind and bit offset per symbol phase and bit
    localparam logic [2:0] C_PLAN_KIND [0:4][0:7] = '{
        '{3'd0, 3'd2, 3'd4, 3'd1, 3'd3, 3'd0, 3'd2, 3'd4},
        '{3'd1, 3'd3, 3'd0, 3'd2, 3'd4, 3'd1, 3'd3, 3'd0},
        '{3'd2, 3'd4, 3'd1, 3'd3, 3'd0, 3'd2, 3'd4, 3'd1},
        '{3'd3, 3'd0, 3'd2, 3'd4, 3'd1, 3'd3, 3'd0, 3'd2},
        '{3'd4, 3'd1, 3'd3, 3'd0, 3'd2, 3'd4, 3'd1, 3'd3}};
    localparam logic [4:0] C_PLAN_OFF [0:4][0:7] = '{
        '{5'd0, 5'd2, 5'd4, 5'd7, 5'd9,  5'd12, 5'd14, 5'd16},
        '{5'd0, 5'd2, 5'd5, 5'd7, 5'd9,  5'd12, 5'd14, 5'd17},
        '{5'd0, 5'd2, 5'd5, 5'd7, 5'd10, 5'd12, 5'd14, 5'd17},
        '{5'd0, 5'd3, 5'd5, 5'd7, 5'd10, 5'd12, 5'd15, 5'd17},
        '{5'd0, 5'd3, 5'd5, 5'd8, 5'd10, 5'd12, 5'd15, 5'd17}};
    localparam logic [4:0] C_PLAN_ADV [0:4] = '{5'd19, 5'd19, 5'd19, 5'd19, 5'd20};

    // downlink formats
    localparam logic [4:0] DF_SHORT_ACAS = 5'd0;
    localparam logic [4:0] DF_ALT_REPLY  = 5'd4;
    localparam logic [4:0] DF_ID_REPLY   = 5'd5;
    localparam logic [4:0] DF_ALL_CALL   = 5'd11;
    localparam logic [4:0] DF_LONG_ACAS  = 5'd16;
    localparam logic [4:0] DF_EXT_SQ     = 5'd17;
    localparam logic [4:0] DF_TISB       = 5'd18;
    localparam logic [4:0] DF_COMMB_ALT  = 5'd20;
    localparam logic [4:0] DF_COMMB_ID   = 5'd21;
    localparam logic [4:0] DF_COMMD      = 5'd24;

    function automatic logic df_is_short(input logic [4:0] df);
        return (df == DF_SHORT_ACAS) || (df == DF_ALT_REPLY) ||
               (df == DF_ID_REPLY) || (df == DF_ALL_CALL);
    endfunction

    function automatic logic df_is_long(input logic [4:0] df);
        return (df == DF_LONG_ACAS) || (df == DF_EXT_SQ) || (df == DF_TISB) ||
               (df == DF_COMMB_ALT) || (df == DF_COMMB_ID) || (df == DF_COMMD);
    endfunction

    // back end status seen by the top level's overwrite guard
    typedef struct packed {
        logic        active;
        logic [31:0] pos;
    } t_bstat;

endpackage

/* sv/mspd_front.sv */
// Front end: sample shift line, write pointer and preamble test.
module mspd_front import mspd_pkg::*; #(
    parameter int WINDOW_DEPTH = C_WINDOW_DEPTH,
    localparam int AW = $clog2(WINDOW_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  logic [15:0]   i_sample,
    output logic          o_busy,
    output logic [31:0]   o_cnt,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [15:0]   o_wr_data,
    output logic          o_push,
    output logic [31:0]   o_pos,
    output logic [AW-1:0] o_slot
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_SUM  = 3'b010,
        F_CHK  = 3'b100
    } t_fstate;

    localparam int BACK = C_PRE_LEN - 1;

    t_fstate       r_state;
    logic [4:0]    r_fill, n_fill;
    logic [31:0]   r_cnt;
    logic [AW-1:0] r_wptr;
    logic [15:0]   r_win [0:C_PRE_LEN-1];
    logic [31:0]   r_ppos;
    logic [AW-1:0] r_pslot;
    logic          r_pre_ok, n_pre_ok;
    logic [18:0]   r_hsum, n_hsum;
    logic [17:0]   r_sig, n_sig;
    logic [17:0]   r_noise, n_noise;
    logic [15:0]   thr;
    logic          quiet, snr_ok;

    assign n_fill = (r_fill == 5'(C_PRE_LEN)) ? r_fill : r_fill + 5'd1;

    // peak pattern select, first matching pattern wins
    always_comb begin
        n_pre_ok = 1'b1;
        n_hsum   = '0;
        n_sig    = '0;
        n_noise  = '0;
        if (r_win[1] > r_win[2] && r_win[2] < r_win[3] && r_win[3] > r_win[4] &&
            r_win[8] < r_win[9] && r_win[9] > r_win[10] && r_win[10] < r_win[11]) begin
            n_hsum  = 19'(r_win[1]) + 19'(r_win[3]) + 19'(r_win[9]) + 19'(r_win[11])
                    + 19'(r_win[12]);
            n_sig   = 18'(r_win[1]) + 18'(r_win[3]) + 18'(r_win[9]);
            n_noise = 18'(r_win[5]) + 18'(r_win[6]) + 18'(r_win[7]);
        end else if (r_win[1] > r_win[2] && r_win[2] < r_win[3] && r_win[3] > r_win[4] &&
                     r_win[8] < r_win[9] && r_win[9] > r_win[10] &&
                     r_win[11] < r_win[12]) begin
            n_hsum  = 19'(r_win[1]) + 19'(r_win[3]) + 19'(r_win[9]) + 19'(r_win[12]);
            n_sig   = 18'(r_win[1]) + 18'(r_win[3]) + 18'(r_win[9]) + 18'(r_win[12]);
            n_noise = 18'(r_win[5]) + 18'(r_win[6]) + 18'(r_win[7]) + 18'(r_win[8]);
        end else if (r_win[1] > r_win[2] && r_win[2] < r_win[3] && r_win[4] > r_win[5] &&
                     r_win[8] < r_win[9] && r_win[10] > r_win[11] &&
                     r_win[11] < r_win[12]) begin
            n_hsum  = 19'(r_win[1]) + 19'(r_win[3]) + 19'(r_win[4]) + 19'(r_win[9])
                    + 19'(r_win[10]) + 19'(r_win[12]);
            n_sig   = 18'(r_win[1]) + 18'(r_win[12]);
            n_noise = 18'(r_win[6]) + 18'(r_win[7]);
        end else if (r_win[1] > r_win[2] && r_win[3] < r_win[4] && r_win[4] > r_win[5] &&
                     r_win[9] < r_win[10] && r_win[10] > r_win[11] &&
                     r_win[11] < r_win[12]) begin
            n_hsum  = 19'(r_win[1]) + 19'(r_win[4]) + 19'(r_win[10]) + 19'(r_win[12]);
            n_sig   = 18'(r_win[1]) + 18'(r_win[4]) + 18'(r_win[10]) + 18'(r_win[12]);
            n_noise = 18'(r_win[5]) + 18'(r_win[6]) + 18'(r_win[7]) + 18'(r_win[8]);
        end else if (r_win[2] > r_win[3] && r_win[3] < r_win[4] && r_win[4] > r_win[5] &&
                     r_win[9] < r_win[10] && r_win[10] > r_win[11] &&
                     r_win[11] < r_win[12]) begin
            n_hsum  = 19'(r_win[1]) + 19'(r_win[2]) + 19'(r_win[4]) + 19'(r_win[10])
                    + 19'(r_win[12]);
            n_sig   = 18'(r_win[4]) + 18'(r_win[10]) + 18'(r_win[12]);
            n_noise = 18'(r_win[6]) + 18'(r_win[7]) + 18'(r_win[8]);
        end else begin
            n_pre_ok = 1'b0;
        end
        if (!(r_win[0] < r_win[1] && r_win[12] > r_win[13])) begin
            n_pre_ok = 1'b0;
        end
    end

    // high/2 with high = sum/4 is sum/8
    assign thr    = r_hsum[18:3];
    assign snr_ok = {2'b00, r_sig} >= {r_noise, 2'b00};

    always_comb begin
        quiet = 1'b1;
        for (int k = 5; k < C_PRE_LEN; k++) begin
            if ((k < 9 || k > 13) && r_win[k] >= thr) begin
                quiet = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_wptr  <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_acc) begin
                        r_fill  <= n_fill;
                        r_cnt   <= r_cnt + 32'd1;
                        r_wptr  <= (r_wptr == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
                        r_state <= (n_fill == 5'(C_PRE_LEN)) ? F_SUM : F_IDLE;
                    end
                end
                F_SUM:   r_state <= F_CHK;
                F_CHK:   r_state <= F_IDLE;
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_acc) begin
            for (int k = 0; k < C_PRE_LEN - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[C_PRE_LEN-1] <= i_sample;
            r_ppos  <= r_cnt - 32'(BACK);
            r_pslot <= (r_wptr >= AW'(BACK)) ? r_wptr - AW'(BACK)
                                             : r_wptr + AW'(WINDOW_DEPTH - BACK);
        end
        if (r_state == F_SUM) begin
            r_pre_ok <= n_pre_ok;
            r_hsum   <= n_hsum;
            r_sig    <= n_sig;
            r_noise  <= n_noise;
        end
    end

    assign o_busy    = (r_state != F_IDLE);
    assign o_cnt     = r_cnt;
    assign o_wr_en   = i_acc;
    assign o_wr_addr = r_wptr;
    assign o_wr_data = i_sample;
    assign o_push    = (r_state == F_CHK) && r_pre_ok && snr_ok && quiet;
    assign o_pos     = r_ppos;
    assign o_slot    = r_pslot;

endmodule

/* sv/mspd_cq.sv */
// Candidate queue between preamble test and demodulator.
module mspd_cq import mspd_pkg::*; #(
    parameter int W  = 32,
    parameter int QD = C_QUEUE_DEPTH,
    localparam int PW = $clog2(QD),
    localparam int CW = $clog2(QD + 1)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_empty,
    output logic [W-1:0] o_head
);

    logic [W-1:0]  r_mem [0:QD-1];
    logic [PW-1:0] r_rd, r_wr;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(QD - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(QD - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == CW'(QD));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

endmodule

/* sv/mspd_back.sv */
// Back end: sample memory, five-lane streaming slicer and result sequencer.
module mspd_back import mspd_pkg::*; #(
    parameter int WINDOW_DEPTH = C_WINDOW_DEPTH,
    localparam int AW = $clog2(WINDOW_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [15:0]   i_wr_data,
    input  logic [31:0]   i_cnt,
    input  logic          i_q_empty,
    input  logic [31:0]   i_q_pos,
    input  logic [AW-1:0] i_q_slot,
    output logic          o_q_pop,
    output t_bstat        o_stat,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [2:0]    o_try_phase,
    output logic [31:0]   o_preamble_position,
    output logic [55:0]   o_head_bits,
    output logic [55:0]   o_tail_bits,
    output logic          o_is_long,
    output logic          o_last_of_run
);

    typedef enum logic [3:0] {
        B_IDLE   = 4'b0001,
        B_WAIT   = 4'b0010,
        B_STREAM = 4'b0100,
        B_EMIT   = 4'b1000
    } t_bstate;

    localparam int HALF = C_LONG_BITS / 2;

    t_bstate       r_state;
    logic [15:0]   r_mem [0:WINDOW_DEPTH-1];
    logic [15:0]   r_rdata;
    logic [AW-1:0] r_rptr;
    logic [AW:0]   first_sum;
    logic [31:0]   r_pos;
    logic [8:0]    r_k, r_d1k, r_sk, base;
    logic          r_d1v, r_d1z, r_sv, issue;
    logic [15:0]   r_s [0:3];
    logic [2:0]    r_j;

    // per-lane trial state, lane j tries phase j+4
    logic [8:0]             r_lp   [0:C_NUM_TRY-1];
    logic [2:0]             r_lph  [0:C_NUM_TRY-1];
    logic [2:0]             r_lb   [0:C_NUM_TRY-1];
    logic [3:0]             r_li   [0:C_NUM_TRY-1];
    logic [C_LONG_BITS-1:0] r_msg  [0:C_NUM_TRY-1];
    logic [C_NUM_TRY-1:0]   r_long, r_keep, r_done;

    logic [8:0]  tgt  [0:C_NUM_TRY-1];
    logic [7:0]  vbyte [0:C_NUM_TRY-1];
    logic [C_NUM_TRY-1:0] hit, bitv;
    logic signed [20:0] sa, sb, sc, sd;
    logic signed [20:0] corr [0:4];
    logic [4:0]  corr_pos;
    logic        last;

    assign issue     = (r_state == B_STREAM) && (r_k <= 9'(C_K_LAST));
    assign base      = r_sk - 9'd3;
    assign first_sum = {1'b0, i_q_slot} + (AW + 1)'(C_DATA_START);

    // shared correlators on the four newest streamed samples
    always_comb begin
        sa = $signed({5'b0, r_s[0]});
        sb = $signed({5'b0, r_s[1]});
        sc = $signed({5'b0, r_s[2]});
        sd = $signed({5'b0, r_s[3]});
        corr[0] = 21'sd5 * sa - 21'sd3 * sb - 21'sd2 * sc;
        corr[1] = 21'sd4 * sa - sb - 21'sd3 * sc;
        corr[2] = 21'sd3 * sa + sb - 21'sd4 * sc;
        corr[3] = 21'sd2 * sa + 21'sd3 * sb - 21'sd5 * sc;
        corr[4] = sa + 21'sd5 * sb - 21'sd5 * sc - sd;
        for (int m = 0; m < 5; m++) begin
            corr_pos[m] = !corr[m][20] && (corr[m] != '0);
        end
    end

    always_comb begin
        for (int j = 0; j < C_NUM_TRY; j++) begin
            tgt[j]   = r_lp[j] + 9'(C_PLAN_OFF[r_lph[j]][r_lb[j]]);
            hit[j]   = (r_state == B_STREAM) && r_sv && !r_done[j] && (base == tgt[j]);
            bitv[j]  = corr_pos[C_PLAN_KIND[r_lph[j]][r_lb[j]]];
            vbyte[j] = {r_msg[j][6:0], bitv[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_d1v   <= 1'b0;
            r_sv    <= 1'b0;
        end else begin
            r_d1v <= issue;
            r_sv  <= r_d1v;
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= B_WAIT;
                    end
                end
                B_WAIT: begin
                    if ((i_cnt - r_pos) >= 32'(C_LOOKAHEAD)) begin
                        r_state <= B_STREAM;
                    end
                end
                B_STREAM: begin
                    if (r_sv && r_sk == 9'(C_K_LAST)) begin
                        r_state <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    if ((!r_keep[r_j] || i_pop) && r_j == 3'(C_NUM_TRY - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && !i_q_empty) begin
            r_pos  <= i_q_pos;
            r_rptr <= (first_sum < (AW + 1)'(WINDOW_DEPTH)) ? first_sum[AW-1:0]
                    : AW'(first_sum - (AW + 1)'(WINDOW_DEPTH));
            r_k    <= 9'(C_DATA_START);
        end else if (issue) begin
            r_rptr <= (r_rptr == AW'(WINDOW_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            r_k    <= r_k + 9'd1;
        end
        r_d1k <= r_k;
        r_d1z <= (r_k >= 9'(C_LOOKAHEAD));
        if (r_d1v) begin
            r_s[0] <= r_s[1];
            r_s[1] <= r_s[2];
            r_s[2] <= r_s[3];
            r_s[3] <= r_d1z ? 16'd0 : r_rdata;
            r_sk   <= r_d1k;
        end
        if (r_state == B_STREAM) begin
            r_j <= '0;
        end else if (r_state == B_EMIT && !r_keep[r_j] || i_pop) begin
            r_j <= r_j + 3'd1;
        end
    end

    // lane updates: one bit whenever the stream reaches the lane's next offset
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < C_NUM_TRY; j++) begin
            if (r_state == B_IDLE && !i_q_empty) begin
                r_lp[j]   <= 9'(C_DATA_START + (j + 4) / 5);
                r_lph[j]  <= 3'((j + 4) % 5);
                r_lb[j]   <= '0;
                r_li[j]   <= '0;
                r_long[j] <= 1'b1;
                r_keep[j] <= 1'b1;
                r_done[j] <= 1'b0;
            end else if (hit[j]) begin
                r_msg[j] <= {r_msg[j][C_LONG_BITS-2:0], bitv[j]};
                r_lb[j]  <= r_lb[j] + 3'd1;
                if (r_lb[j] == 3'd7) begin
                    r_lp[j]  <= r_lp[j] + 9'(C_PLAN_ADV[r_lph[j]]);
                    r_lph[j] <= (r_lph[j] == 3'd4) ? 3'd0 : r_lph[j] + 3'd1;
                    r_li[j]  <= r_li[j] + 4'd1;
                    if (r_li[j] == 4'd0) begin
                        if (df_is_short(vbyte[j][7:3])) begin
                            r_long[j] <= 1'b0;
                        end else if (!df_is_long(vbyte[j][7:3])) begin
                            r_keep[j] <= 1'b0;
                            r_done[j] <= 1'b1;
                        end
                    end else if (r_li[j] == (r_long[j] ? 4'(C_LONG_BITS / 8 - 1)
                                                       : 4'(C_SHORT_BITS / 8 - 1))) begin
                        r_done[j] <= 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        last = 1'b1;
        for (int m = 0; m < C_NUM_TRY; m++) begin
            if (3'(m) > r_j && r_keep[m]) begin
                last = 1'b0;
            end
        end
    end

    assign o_q_pop             = (r_state == B_IDLE) && !i_q_empty;
    assign o_stat.active       = (r_state == B_WAIT) || (r_state == B_STREAM);
    assign o_stat.pos          = r_pos;
    assign o_empty             = !((r_state == B_EMIT) && r_keep[r_j]);
    assign o_try_phase         = r_j;
    assign o_preamble_position = r_pos;
    assign o_is_long           = r_long[r_j];
    assign o_head_bits         = r_long[r_j] ? r_msg[r_j][C_LONG_BITS-1:HALF]
                                             : r_msg[r_j][HALF-1:0];
    assign o_tail_bits         = r_long[r_j] ? r_msg[r_j][HALF-1:0] : '0;
    assign o_last_of_run       = last;

endmodule

/* sv/mode_s_preamble_detect_demod.sv */
// Top level of the Mode S preamble detector and PPM demodulator.
//
// Takes 2.4 MS/s magnitude samples through a push/full queue port and hands
// out demodulated message candidates through an empty/pop queue port. Every
// sample position is tested as a preamble start (edges, five peak patterns,
// signal to noise, quiet slots). The front end shifts each sample into a
// 19-sample line and writes it into the sample ring; once the line is full,
// a pattern/sum stage and a threshold stage follow before it takes the next
// sample. A passing position enters a four-entry candidate queue.
// The back end pops a candidate, waits until the 290 samples starting at it
// are in the ring, then streams samples 19..292 of that window out of the
// ring memory at one sample per cycle, slicing all five trial phases in
// parallel lanes that share one set of correlators. It then offers one
// transaction per surviving phase, in phase order, with last_of_run on the
// final one; dropped phases are skipped with no transaction. full rises
// while the front end is busy, while the candidate
// queue is full, or when the next sample would overwrite ring samples still
// owed to the oldest pending candidate, so a long burst of candidates or a
// stalled consumer back-pressures the sample input. No reset sweep of the
// ring is needed: positions are only tested once enough samples exist.
module mode_s_preamble_detect_demod import mspd_pkg::*; #(
    parameter int WINDOW_DEPTH = C_WINDOW_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_sample,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_try_phase,
    output logic [31:0] o_preamble_position,
    output logic [55:0] o_head_bits,
    output logic [55:0] o_tail_bits,
    output logic        o_is_long,
    output logic        o_last_of_run
);

`include "mode_s_preamble_detect_demod_macros.svh"

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int QW = 32 + AW;

    logic          acc;
    logic          f_busy;
    logic [31:0]   f_cnt;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          q_push, q_pop, q_full, q_empty;
    logic [31:0]   c_pos;
    logic [AW-1:0] c_slot;
    logic [QW-1:0] q_head;
    t_bstat        b_stat;
    logic [31:0]   oldest;
    logic          hazard;

    // the oldest candidate still needing ring data: the one being demodulated,
    // else the head of the queue
    assign oldest = b_stat.active ? b_stat.pos : q_head[QW-1:AW];
    assign hazard = (b_stat.active || !q_empty) && ((f_cnt - oldest) >= 32'(WINDOW_DEPTH));
    assign full   = f_busy || q_full || hazard;
    assign acc    = push && !full;

    mspd_front #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_sample  (i_sample),
        .o_busy    (f_busy),
        .o_cnt     (f_cnt),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_push    (q_push),
        .o_pos     (c_pos),
        .o_slot    (c_slot)
    );

    mspd_cq #(
        .W  (QW),
        .QD (C_QUEUE_DEPTH)
    ) u_cq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({c_pos, c_slot}),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    mspd_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_wr_en             (wr_en),
        .i_wr_addr           (wr_addr),
        .i_wr_data           (wr_data),
        .i_cnt               (f_cnt),
        .i_q_empty           (q_empty),
        .i_q_pos             (q_head[QW-1:AW]),
        .i_q_slot            (q_head[AW-1:0]),
        .o_q_pop             (q_pop),
        .o_stat              (b_stat),
        .o_empty             (empty),
        .i_pop               (pop),
        .o_try_phase         (o_try_phase),
        .o_preamble_position (o_preamble_position),
        .o_head_bits         (o_head_bits),
        .o_tail_bits         (o_tail_bits),
        .o_is_long           (o_is_long),
        .o_last_of_run       (o_last_of_run)
    );

    // ring never runs more than one full lap ahead of the active candidate
    `MSPD_ASSERT_NOW(a_ring_safe, i_clk, i_rst_n, b_stat.active, (f_cnt - b_stat.pos) <= 32'(WINDOW_DEPTH), "sample ring overran active candidate")
    // a candidate always finds room in the queue
    `MSPD_ASSERT_NOW(a_push_room, i_clk, i_rst_n, q_push, !q_full, "candidate pushed into full queue")
    // taking the last transaction of a run leaves nothing to pop
    `MSPD_ASSERT_NEXT(a_run_end, i_clk, i_rst_n, pop && !empty && o_last_of_run, empty, "result offered after end of run")

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the Mode S preamble detector and PPM demodulator.
module testbench import mspd_pkg::*;;

    localparam int LIMIT_CYCLES = 900000;
    localparam int N_ITEMS      = 470;
    localparam int N_FRAMES     = 18;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 700;

    // one expected or observed candidate transaction
    typedef struct {
        logic [2:0]  phase;
        logic [31:0] pos;
        logic [55:0] head;
        logic [55:0] tail;
        logic        long_msg;
        logic        last;
    } cand_t;

    // Scoreboard: own copy of the sample window and counter, predicts the
    // candidates for every accepted sample and checks popped transactions.
    class demod_scoreboard;
        logic [15:0] win[C_LOOKAHEAD];   // win[0] is the oldest sample
        logic [31:0] n_samples;
        int          fill;
        cand_t       expected_q[$];
        int          errors;

        function new();
            foreach (win[k]) win[k] = '0;
            n_samples = '0;
            fill      = 0;
            errors    = 0;
        endfunction

        function int wv(int i);
            return (i < C_LOOKAHEAD) ? int'(win[i]) : 0;
        endfunction

        function int corr(int kind, int p);
            int a, b, c;
            a = wv(p);
            b = wv(p + 1);
            c = wv(p + 2);
            case (kind)
                0: return 5 * a - 3 * b - 2 * c;
                1: return 4 * a - b - 3 * c;
                2: return 3 * a + b - 4 * c;
                3: return 2 * a + 3 * b - 5 * c;
                default: return a + 5 * b - 5 * c - wv(p + 3);
            endcase
        endfunction

        function bit preamble_found();
            int w[19];
            int high, sig, noise;
            foreach (w[k]) w[k] = int'(win[k]);
            if (!(w[0] < w[1] && w[12] > w[13])) return 0;
            if (w[1] > w[2] && w[2] < w[3] && w[3] > w[4] && w[8] < w[9] &&
                w[9] > w[10] && w[10] < w[11]) begin
                high  = (w[1] + w[3] + w[9] + w[11] + w[12]) / 4;
                sig   = w[1] + w[3] + w[9];
                noise = w[5] + w[6] + w[7];
            end else if (w[1] > w[2] && w[2] < w[3] && w[3] > w[4] && w[8] < w[9] &&
                         w[9] > w[10] && w[11] < w[12]) begin
                high  = (w[1] + w[3] + w[9] + w[12]) / 4;
                sig   = w[1] + w[3] + w[9] + w[12];
                noise = w[5] + w[6] + w[7] + w[8];
            end else if (w[1] > w[2] && w[2] < w[3] && w[4] > w[5] && w[8] < w[9] &&
                         w[10] > w[11] && w[11] < w[12]) begin
                high  = (w[1] + w[3] + w[4] + w[9] + w[10] + w[12]) / 4;
                sig   = w[1] + w[12];
                noise = w[6] + w[7];
            end else if (w[1] > w[2] && w[3] < w[4] && w[4] > w[5] && w[9] < w[10] &&
                         w[10] > w[11] && w[11] < w[12]) begin
                high  = (w[1] + w[4] + w[10] + w[12]) / 4;
                sig   = w[1] + w[4] + w[10] + w[12];
                noise = w[5] + w[6] + w[7] + w[8];
            end else if (w[2] > w[3] && w[3] < w[4] && w[4] > w[5] && w[9] < w[10] &&
                         w[10] > w[11] && w[11] < w[12]) begin
                high  = (w[1] + w[2] + w[4] + w[10] + w[12]) / 4;
                sig   = w[4] + w[10] + w[12];
                noise = w[6] + w[7] + w[8];
            end else begin
                return 0;
            end
            if (sig * 2 < 8 * noise) return 0;
            for (int k = 5; k <= 18; k++)
                if ((k < 9 || k > 13) && w[k] >= high / 2) return 0;
            return 1;
        endfunction

        // accepted sample: shift it in and queue the candidates it produces
        function void note_sample(logic [15:0] s);
            logic [31:0] pos;
            logic [7:0]  msg[14];
            logic [4:0]  df;
            cand_t       c;
            int          nbytes, ph, p, first;
            bit          keep;
            for (int k = 0; k < C_LOOKAHEAD - 1; k++) win[k] = win[k + 1];
            win[C_LOOKAHEAD - 1] = s;
            pos       = n_samples - 32'(C_LOOKAHEAD - 1);
            n_samples = n_samples + 1;
            if (fill < C_LOOKAHEAD) fill++;
            if (fill < C_LOOKAHEAD || !preamble_found()) return;
            first = expected_q.size();
            for (int tp = 4; tp <= 8; tp++) begin
                nbytes = 14;
                ph     = tp % 5;
                p      = C_DATA_START + tp / 5;
                keep   = 1;
                foreach (msg[i]) msg[i] = '0;
                for (int i = 0; i < nbytes; i++) begin
                    for (int b = 0; b < 8; b++)
                        msg[i][7 - b] = corr(C_PLAN_KIND[ph][b], p + C_PLAN_OFF[ph][b]) > 0;
                    p  = p + C_PLAN_ADV[ph];
                    ph = (ph + 1) % 5;
                    if (i == 0) begin
                        df = msg[0][7:3];
                        if (df inside {DF_SHORT_ACAS, DF_ALT_REPLY, DF_ID_REPLY, DF_ALL_CALL})
                            nbytes = 7;
                        else if (!(df inside {DF_LONG_ACAS, DF_EXT_SQ, DF_TISB,
                                              DF_COMMB_ALT, DF_COMMB_ID, DF_COMMD})) begin
                            keep = 0;
                            break;
                        end
                    end
                end
                if (!keep) continue;
                c.phase    = 3'(tp - 4);
                c.pos      = pos;
                c.long_msg = nbytes > 7;
                c.last     = 0;
                c.head     = '0;
                c.tail     = '0;
                for (int i = 0; i < 7; i++) begin
                    c.head = {c.head[47:0], msg[i]};
                    c.tail = {c.tail[47:0], (nbytes > 7) ? msg[i + 7] : 8'h00};
                end
                expected_q.push_back(c);
            end
            if (expected_q.size() > first) expected_q[$].last = 1;
        endfunction

        function void check_result(cand_t r);
            cand_t e;
            if (expected_q.size() == 0) begin
                $error("unexpected candidate: phase %0d pos %0d", r.phase, r.pos);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (r.phase !== e.phase) begin
                $error("try_phase: expected %0d, actual %0d", e.phase, r.phase);
                errors++;
            end
            if (r.pos !== e.pos) begin
                $error("preamble_position: expected %0d, actual %0d", e.pos, r.pos);
                errors++;
            end
            if (r.head !== e.head) begin
                $error("head_bits: expected %h, actual %h", e.head, r.head);
                errors++;
            end
            if (r.tail !== e.tail) begin
                $error("tail_bits: expected %h, actual %h", e.tail, r.tail);
                errors++;
            end
            if (r.long_msg !== e.long_msg) begin
                $error("is_long: expected %0d, actual %0d", e.long_msg, r.long_msg);
                errors++;
            end
            if (r.last !== e.last) begin
                $error("last_of_run: expected %0d, actual %0d", e.last, r.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        push = 0;
    logic        pop = 0;
    logic [15:0] i_sample = '0;
    logic        full, empty;
    logic [2:0]  o_try_phase;
    logic [31:0] o_preamble_position;
    logic [55:0] o_head_bits, o_tail_bits;
    logic        o_is_long, o_last_of_run;

    demod_scoreboard sb = new();

    int  send_idle_pct = 34;   // sender idles this often (percent)
    int  recv_idle_pct = 50;   // receiver idles this often (percent)
    bit  hold_request  = 0;    // asks the receiver for one long hold-off
    int  n_sent        = 0;
    int  n_cycles      = 0;
    bit  stim_done     = 0;

    mode_s_preamble_detect_demod dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_sample           (i_sample),
        .empty              (empty),
        .pop                (pop),
        .o_try_phase        (o_try_phase),
        .o_preamble_position(o_preamble_position),
        .o_head_bits        (o_head_bits),
        .o_tail_bits        (o_tail_bits),
        .o_is_long          (o_is_long),
        .o_last_of_run      (o_last_of_run)
    );

    always #2 i_clk = ~i_clk;

    // watchdog: a hang anywhere ends the run as a failure
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one sample; random idle cycles first. push stays high between
    // back-to-back transactions, so it gets only one assignment per edge.
    task automatic put_sample(input logic [15:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push     <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (full);   // full sampled before the edge's updates
        sb.note_sample(s);
        n_sent++;
    endtask

    // Crafted preamble for one of the five peak patterns, then a PPM message
    // rendered at tenth-sample resolution with a random chip offset, so the
    // trial phases see shifted symbols. The DF is mostly a known one.
    task automatic send_frame();
        logic [18:0] hi_mask;
        logic [4:0]  known_df[10];
        bit          msg_bit[112];
        bit          chip_on[3100];
        logic [4:0]  df;
        int          amp, shift, acc, v;
        known_df = '{DF_SHORT_ACAS, DF_ALT_REPLY, DF_ID_REPLY, DF_ALL_CALL, DF_LONG_ACAS,
                     DF_EXT_SQ, DF_TISB, DF_COMMB_ALT, DF_COMMB_ID, DF_COMMD};
        case ($urandom_range(4))
            0: hi_mask = 19'b0000001101000001010;   // slots 1,3,9,11,12
            1: hi_mask = 19'b0000001001000001010;   // slots 1,3,9,12
            2: hi_mask = 19'b0000001011000011010;   // slots 1,3,4,9,10,12
            3: hi_mask = 19'b0000001010000010010;   // slots 1,4,10,12
            default: hi_mask = 19'b0000001010000010100;   // slots 2,4,10,12
        endcase
        amp   = $urandom_range(12000, 60000);
        shift = $urandom_range(14);
        df    = ($urandom_range(99) < 85) ? known_df[$urandom_range(9)] : 5'($urandom);
        foreach (msg_bit[i]) msg_bit[i] = $urandom_range(1);
        for (int i = 0; i < 5; i++) msg_bit[i] = df[4 - i];
        foreach (chip_on[t]) chip_on[t] = 0;
        foreach (msg_bit[i])
            for (int t = 0; t < 12; t++)
                chip_on[190 + shift + 24 * i + (msg_bit[i] ? 0 : 12) + t] = 1;
        for (int j = 0; j < 295; j++) begin
            if (j == 0)
                v = 0;                                  // leading edge needs w0 < w1
            else if (j < 19)
                v = hi_mask[j] ? amp - $urandom_range(amp / 16)
                               : $urandom_range(1, amp / 12);
            else begin
                acc = 0;
                for (int t = 0; t < 10; t++) acc += chip_on[10 * j + t];
                v = $urandom_range(1, amp / 12) + amp * acc / 10;
            end
            put_sample(16'(v));
        end
    endtask

    // Receiver: random pop with one long hold-off on request.
    initial begin
        cand_t r;
        int    hold_left;
        hold_left = 0;
        forever begin
            if (hold_request) begin
                hold_request = 0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) hold_left--;
            pop <= i_rst_n && hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
            @(posedge i_clk);
            if (pop && !empty) begin
                r.phase    = o_try_phase;
                r.pos      = o_preamble_position;
                r.head     = o_head_bits;
                r.tail     = o_tail_bits;
                r.long_msg = o_is_long;
                r.last     = o_last_of_run;
                sb.check_result(r);
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [15:0] directed[$];
        int          n_frames;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes and bit patterns; these also count toward the warm-up span
        directed = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                     16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE, 16'h00FF, 16'hFF00,
                     16'h0F0F, 16'hF0F0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF};
        foreach (directed[k]) put_sample(directed[k]);

        // mostly well-formed frames, with noise bursts between them
        n_frames = 0;
        while (n_sent < N_ITEMS || n_frames < N_FRAMES) begin
            if (n_frames == N_FRAMES / 3) begin
                send_idle_pct = 50;
                recv_idle_pct = 34;
            end else if (n_frames == 2 * N_FRAMES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n_frames == 2) hold_request = 1;   // consumer stalls, input backs up
            if (n_frames == 9) begin
                // sender pause until every expected candidate is out
                push <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
            if ($urandom_range(99) < 85) begin
                send_frame();
                n_frames++;
            end else
                repeat ($urandom_range(1, 40)) put_sample(16'($urandom));
        end
        push <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);   // catch stray extra candidates
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/mspd_pkg.sv
sv/mspd_front.sv
sv/mspd_cq.sv
sv/mspd_back.sv
sv/mode_s_preamble_detect_demod.sv
verif/testbench.sv
